@@ rtl/chip_voice_synth_macros.svh @@
// Assertion macros used by chip_voice_synth.sv.
`ifndef CHIP_VOICE_SYNTH_MACROS_SVH
`define CHIP_VOICE_SYNTH_MACROS_SVH

// Whenever the condition holds, the property must hold as well.
`define CVS_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Whenever the condition holds, the property must hold in the next cycle.
`define CVS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

@@ rtl/cvs_pkg.sv @@
`default_nettype none
package cvs_pkg;
   localparam int unsigned VoicesDefault    = 8;
   localparam int unsigned PhaseBitsDefault = 24;
   localparam int unsigned RateBits         = 40;
   localparam int unsigned GlideBits        = 32;
   localparam int unsigned SampleBits       = 16;
   localparam int unsigned EnvBits          = 17;
   localparam int unsigned AccBits          = 48;

   localparam logic [7:0]  MasterReset  = 8'd204;
   localparam logic [23:0] MinIncReset  = 24'd6990;
   localparam logic [31:0] SeedReset    = 32'h0123_4567;
   localparam logic [31:0] LcgMul       = 32'd1664525;
   localparam logic [31:0] LcgAdd       = 32'd1013904223;
   localparam logic [15:0] HeadroomQ16  = 16'd22938;

   localparam logic [0:0] CsrMaster = 1'b0;
   localparam logic [0:0] CsrMinInc = 1'b1;

   localparam logic [1:0] WavePulse = 2'd0;
   localparam logic [1:0] WaveSaw   = 2'd1;
   localparam logic [1:0] WaveTri   = 2'd2;
   localparam logic [1:0] WaveNoise = 2'd3;

   // The first member lands in the highest bits, so action ends up in bit 0.
   typedef struct packed {
      logic [15:0] duration;
      logic [7:0]  volume;
      logic [7:0]  duty;
      logic [31:0] sweep;
      logic [23:0] increment;
      logic [1:0]  wave;
      logic        action;
   } req_type;

   // Control between the sequencer and the divider.
   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;
endpackage
`default_nettype wire

@@ rtl/cvs_div.sv @@
`default_nettype none
// Restoring divider: floor((num << 16) / den), one quotient bit per cycle.
module cvs_div
   import cvs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [15:0]         num,
   input  wire logic [15:0]         den,
   output div_ctl_type              ctl,
   output logic      [EnvBits-1:0]  quot
);
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [15:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [EnvBits-1:0] q_ff, q_in;
   logic [32:0] shifted;

   always_comb begin
      rem_in = rem_ff; dvd_in = dvd_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; q_in = q_ff;
      shifted = {rem_ff[31:0], dvd_ff[31]};
      if (start) begin
         rem_in = '0; dvd_in = {num, 16'd0}; den_in = den;
         cnt_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         if (shifted >= {17'd0, den_ff}) begin
            rem_in = shifted - {17'd0, den_ff};
            q_in = {q_ff[EnvBits-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in = {q_ff[EnvBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in; dvd_ff <= dvd_in; den_ff <= den_in; q_ff <= q_in;
   end

   // The quotient fits 17 bits when num <= den (num == den gives 2^16);
   // the voice logic never lets left exceed length.
   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

@@ rtl/chip_voice_synth.sv @@
`default_nettype none
// Channel  | Direction | Payload
// req_     | in        | start-note or tick command
// rsp_     | out       | one mixed sample per tick
// csr_     | in        | master gain and increment floor writes
// A start-note item scans one voice per cycle until an idle one or the last is reached.
// A tick takes each active voice through a wait on the 32 steps of the
// envelope divider, then two multiply steps and the update; an idle voice is
// skipped, and the mix and output steps follow.
// Reset is synchronous; all voices go idle and the noise seed reloads.
// The block accepts no item while one is at work; a finished tick holds in
// its output step only while an earlier sample still waits.
`include "chip_voice_synth_macros.svh"
module chip_voice_synth
   import cvs_pkg::*;
#(
   parameter int unsigned VOICES     = VoicesDefault,
   parameter int unsigned PHASE_BITS = PhaseBitsDefault
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] action, [2:1] wave, [26:3] increment, [58:27] sweep, [66:59] duty,
   // [74:67] volume, [90:75] duration, [95:91] zero
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] sample
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [23:0] csr_wdata
);
   localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_PICK, S_LOAD, S_VSEL, S_DIVW, S_MUL1, S_MUL2, S_UPD,
      S_MIX1, S_MIX2, S_MIX3, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [7:0]  master_ff;
   logic [23:0] mininc_ff;
   req_type     req_ff;
   logic [VW-1:0] idx_ff, best_ff;
   logic [23:0] best_key_ff;
   logic        found_ff;
   logic [31:0] seed_ff;
   logic signed [AccBits-1:0] acc_ff;
   logic signed [17:0] w_ff;
   logic signed [40:0] prod_ff;
   logic [63:0] m_ff;
   logic [15:0] out_ff;
   logic        rsp_valid_ff;

   logic                  active_ff [VOICES];
   logic [1:0]            wave_ff   [VOICES];
   logic [PHASE_BITS-1:0] phase_ff  [VOICES];
   logic [RateBits-1:0]   rate_ff   [VOICES];
   logic signed [31:0]    glide_ff  [VOICES];
   logic [7:0]            pw_ff     [VOICES];
   logic [7:0]            gain_ff   [VOICES];
   logic [15:0]           left_ff   [VOICES];
   logic [15:0]           length_ff [VOICES];

   logic        div_start;
   div_ctl_type div_ctl;
   logic [EnvBits-1:0] env;

   cvs_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(left_ff[idx_ff]), .den(length_ff[idx_ff]), .ctl(div_ctl), .quot(env)
   );

   logic [23:0] key;
   logic [15:0] p16;
   logic signed [17:0] w_sel;
   logic [31:0] seed_next;
   logic signed [42:0] r_new;
   logic [42:0] floor_r;
   logic [RateBits-1:0] r_sat;
   logic [47:0] mag;
   logic last_voice;
   logic req_in_ok;
   logic out_load;
   logic [15:0] out_mag;

   assign key = gain_ff[idx_ff] * left_ff[idx_ff];
   assign p16 = phase_ff[idx_ff][PHASE_BITS-1 -: 16];
   assign seed_next = seed_ff * LcgMul + LcgAdd;
   assign last_voice = (idx_ff == VW'(VOICES - 1));
   assign floor_r = {3'd0, mininc_ff, 16'd0};
   assign mag = acc_ff[AccBits-1] ? 48'(-acc_ff) : 48'(acc_ff);

   always_comb begin
      case (wave_ff[idx_ff])
         WavePulse: w_sel = (phase_ff[idx_ff][PHASE_BITS-1 -: 8] < pw_ff[idx_ff]) ?
                            18'sd32768 : -18'sd32768;
         WaveSaw:   w_sel = $signed({2'b00, p16}) - 18'sd32768;
         WaveTri:   w_sel = p16[15] ? ($signed({1'b0, p16[14:0], 1'b0}) - 18'sd32768)
                                    : ($signed({1'b0, ~p16[14:0], 1'b0}) - 18'sd32766);
         default:   w_sel = $signed({2'b00, seed_next[24:9]}) - 18'sd32768;
      endcase
      r_new = $signed({3'd0, rate_ff[idx_ff]}) + 43'(glide_ff[idx_ff]);
      if (r_new < $signed(floor_r)) r_new = $signed(floor_r);
      if (r_new > $signed({3'd0, {RateBits{1'b1}}})) r_sat = {RateBits{1'b1}};
      else r_sat = r_new[RateBits-1:0];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign div_start  = (state_ff == S_VSEL) && active_ff[idx_ff];
   assign req_in_ok  = req_tvalid && req_tready;
   // A new sample enters the output register once the previous one has left.
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign out_mag    = (m_ff > 64'd32767) ? 16'd32767 : m_ff[15:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_in_ok) state_in = req_tdata[0] ? S_VSEL : S_PICK;
         S_PICK: if (!active_ff[idx_ff] || last_voice) state_in = S_LOAD;
         S_LOAD: state_in = S_IDLE;
         S_VSEL: state_in = active_ff[idx_ff] ? S_DIVW : (last_voice ? S_MIX1 : S_VSEL);
         S_DIVW: if (!div_ctl.busy && !div_ctl.start) state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_UPD;
         S_UPD:  state_in = last_voice ? S_MIX1 : S_VSEL;
         S_MIX1: state_in = S_MIX2;
         S_MIX2: state_in = S_MIX3;
         S_MIX3: state_in = S_OUT;
         S_OUT:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         master_ff <= MasterReset;
         mininc_ff <= MinIncReset;
         seed_ff <= SeedReset;
         idx_ff <= '0;
         for (int i = 0; i < VOICES; i++) begin
            active_ff[i] <= 1'b0; wave_ff[i] <= WavePulse; phase_ff[i] <= '0;
            rate_ff[i] <= '0; glide_ff[i] <= '0; pw_ff[i] <= 8'd128;
            gain_ff[i] <= '0; left_ff[i] <= '0; length_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_index == CsrMaster) master_ff <= csr_wdata[7:0];
            else mininc_ff <= csr_wdata;
         end
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_in_ok) begin
               req_ff <= req_tdata[90:0];
               idx_ff <= '0; found_ff <= 1'b0; acc_ff <= '0;
            end
            S_PICK: begin
               if (!active_ff[idx_ff]) best_ff <= idx_ff;
               else begin
                  if (!found_ff || key < best_key_ff) begin
                     best_ff <= idx_ff; best_key_ff <= key; found_ff <= 1'b1;
                  end
                  if (!last_voice) idx_ff <= idx_ff + 1'b1;
               end
            end
            S_LOAD: begin
               active_ff[best_ff] <= 1'b1;
               wave_ff[best_ff]   <= req_ff.wave;
               phase_ff[best_ff]  <= '0;
               rate_ff[best_ff]   <= {req_ff.increment, 16'd0};
               glide_ff[best_ff]  <= req_ff.sweep;
               pw_ff[best_ff]     <= req_ff.duty;
               gain_ff[best_ff]   <= req_ff.volume;
               left_ff[best_ff]   <= req_ff.duration;
               length_ff[best_ff] <= req_ff.duration;
            end
            S_VSEL: if (active_ff[idx_ff]) begin
               w_ff <= w_sel;
               if (wave_ff[idx_ff] == WaveNoise) seed_ff <= seed_next;
            end else if (!last_voice) idx_ff <= idx_ff + 1'b1;
            S_DIVW: ;
            S_MUL1: prod_ff <= 41'(w_ff * $signed({1'b0, gain_ff[idx_ff]}));
            S_MUL2: acc_ff <= acc_ff + AccBits'(prod_ff *
                              $signed({1'b0, (length_ff[idx_ff] == 16'd0) ? 16'd0 : env}));
            S_UPD: begin
               rate_ff[idx_ff]  <= r_sat;
               phase_ff[idx_ff] <= phase_ff[idx_ff] +
                                   r_sat[RateBits-1 -: PHASE_BITS];
               if (left_ff[idx_ff] <= 16'd1) begin
                  left_ff[idx_ff] <= '0; active_ff[idx_ff] <= 1'b0;
               end else left_ff[idx_ff] <= left_ff[idx_ff] - 16'd1;
               if (!last_voice) idx_ff <= idx_ff + 1'b1;
            end
            S_MIX1: begin
               m_ff <= 64'(mag) * 64'(master_ff);
            end
            S_MIX2: begin
               if (m_ff > 64'd562949953421312) m_ff <= 64'd562949953421312;
            end
            S_MIX3: m_ff <= ((m_ff[49:0] * HeadroomQ16) + 64'd140737488355328) >> 48;
            S_OUT: begin
               if (out_load) out_ff <= acc_ff[AccBits-1] ? 16'd0 - out_mag : out_mag;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_ff;

   `CVS_ASSERT_IMPL(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_tready)
   `CVS_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == S_OUT, rsp_tvalid)
   `CVS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule
`default_nettype wire
